[hdl/caws_pkg.sv]
package caws_pkg;

  // Field widths
  localparam int SECTOR_W    = 32;
  localparam int LEN_W       = 16;
  localparam int AREA_SIZE_W = 17;
  localparam int SEQ_W       = 32;
  localparam int OP_W        = 8;

  // Area size after reset, in sectors
  localparam logic [AREA_SIZE_W-1:0] AREA_SIZE_RESET = AREA_SIZE_W'(8);

  // Restoring divider: dividend is one bit wider than a sector number
  localparam int DIV_W     = SECTOR_W + 1;
  localparam int DIV_STEPS = DIV_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Incoming block write request
  typedef struct packed {
    logic [SECTOR_W-1:0] start_sector;
    logic [LEN_W-1:0]    length_sectors;
    logic [OP_W-1:0]     op_code;
  } req_t;

  // One emitted piece
  typedef struct packed {
    logic [SECTOR_W-1:0]    piece_sector;
    logic [AREA_SIZE_W-1:0] piece_sectors;
    logic [SEQ_W-1:0]       sequence_id;
    logic [OP_W-1:0]        piece_op;
    logic                   range_error;
    logic                   last;
  } rsp_t;

endpackage

[hdl/collision_area_write_splitter.sv]
// Collision area write splitter.
// Input channel (in_valid / in_stall / in_data) takes one write request: start
// sector, length and operation code. A transaction is accepted on a rising edge
// with valid high and stall low. The result channel (out_valid / out_stall /
// out_data) returns the pieces of that request in ascending sector order, each
// inside one collision area, with the area's incremented sequence id; the last
// piece of a request has last set. A rejected request gives one result with
// range_error set. cfg_we / cfg_wdata write the area size (0 acts as 1); write
// it only while the block is idle.
// Sequence: the area lookup runs two divisions through one shared restoring
// divider, one quotient bit per cycle, then a range check. Each piece then
// takes a counter memory read step, then an update and result load step.
// in_stall stays high from acceptance until the last piece is loaded.
// After reset the counter memory is cleared one entry per cycle while in_stall
// is high. A stalled receiver holds the result register and the sequencer
// waits before reading the next counter.
module collision_area_write_splitter #(
  parameter int NUM_AREAS  = 1024,
  parameter int MAX_PIECES = 64
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  caws_pkg::req_t                        in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output caws_pkg::rsp_t                        out_data,
  input  logic                                  cfg_we,
  input  logic [caws_pkg::AREA_SIZE_W-1:0]      cfg_wdata
);

  localparam int AW = (NUM_AREAS > 1) ? $clog2(NUM_AREAS) : 1;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_DIV   = 7'b0000100,
    ST_CHECK = 7'b0001000,
    ST_RD    = 7'b0010000,
    ST_WR    = 7'b0100000,
    ST_ERR   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [caws_pkg::AREA_SIZE_W-1:0] area_cfg_r;
  logic [caws_pkg::AREA_SIZE_W-1:0] a_r;
  logic [caws_pkg::SECTOR_W-1:0]    start_r;
  logic [caws_pkg::LEN_W-1:0]       len_r;
  logic [caws_pkg::OP_W-1:0]        op_r;

  logic [caws_pkg::DIV_W-1:0]       quo_r;
  logic [caws_pkg::AREA_SIZE_W-1:0] rem_r;
  logic [caws_pkg::DIV_CNT_W-1:0]   div_cnt_r;
  logic                             div_pass_r;
  logic [caws_pkg::DIV_W-1:0]       first_area_r;
  logic [caws_pkg::AREA_SIZE_W-1:0] first_rem_r;
  logic [caws_pkg::DIV_W-1:0]       last_area_r;

  logic [AW-1:0]                    area_r;
  logic [AW-1:0]                    clr_cnt_r;
  logic [caws_pkg::SECTOR_W-1:0]    pos_r;
  logic [caws_pkg::LEN_W-1:0]       remain_r;
  logic [caws_pkg::AREA_SIZE_W-1:0] room_r;

  logic [caws_pkg::SEQ_W-1:0]       mem [NUM_AREAS];
  logic [caws_pkg::SEQ_W-1:0]       rd_data_r;

  logic                             out_valid_r;
  caws_pkg::rsp_t                   out_data_r;

  // Handshake decode
  logic in_acc;
  logic slot_free;
  logic out_load;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Divider step: shift in one dividend bit, subtract if it fits
  logic [caws_pkg::AREA_SIZE_W:0]   trial;
  logic [caws_pkg::AREA_SIZE_W+1:0] diff;
  logic                             q_bit;
  logic [caws_pkg::AREA_SIZE_W-1:0] rem_step;
  logic [caws_pkg::DIV_W-1:0]       quo_step;
  logic                             div_done;
  assign trial    = {rem_r, quo_r[caws_pkg::DIV_W-1]};
  assign diff     = {1'b0, trial} - {2'b00, a_r};
  assign q_bit    = ~diff[caws_pkg::AREA_SIZE_W+1];
  assign rem_step = q_bit ? diff[caws_pkg::AREA_SIZE_W-1:0]
                          : trial[caws_pkg::AREA_SIZE_W-1:0];
  assign quo_step = {quo_r[caws_pkg::DIV_W-2:0], q_bit};
  assign div_done = (div_cnt_r == caws_pkg::DIV_CNT_W'(caws_pkg::DIV_STEPS - 1));

  // Dividend of the last covered sector
  logic [caws_pkg::DIV_W-1:0] end_sector;
  assign end_sector = (len_r != '0)
                    ? ({1'b0, start_r} + caws_pkg::DIV_W'(len_r) - caws_pkg::DIV_W'(1))
                    : {1'b0, start_r};

  // Range check
  logic [caws_pkg::DIV_W-1:0] span;
  logic                       reject;
  assign span   = last_area_r - first_area_r;
  assign reject = (span >= caws_pkg::DIV_W'(MAX_PIECES)) ||
                  (last_area_r >= caws_pkg::DIV_W'(NUM_AREAS));

  // Piece sizing
  logic [caws_pkg::AREA_SIZE_W-1:0] remain_ext;
  logic [caws_pkg::AREA_SIZE_W-1:0] take;
  logic [caws_pkg::SEQ_W-1:0]       seq_id;
  logic                             piece_last;
  assign remain_ext = caws_pkg::AREA_SIZE_W'(remain_r);
  assign take       = (remain_ext < room_r) ? remain_ext : room_r;
  assign seq_id     = rd_data_r + caws_pkg::SEQ_W'(1);
  assign piece_last = (remain_ext == take);
  assign out_load   = (state_r == ST_WR) || ((state_r == ST_ERR) && slot_free);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_cnt_r == AW'(NUM_AREAS - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_acc) state_nxt = ST_DIV;
      ST_DIV:   if (div_done && div_pass_r) state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = reject ? ST_ERR : ST_RD;
      ST_RD:    if (slot_free) state_nxt = ST_WR;
      ST_WR:    state_nxt = piece_last ? ST_IDLE : ST_RD;
      ST_ERR:   if (slot_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      area_cfg_r  <= caws_pkg::AREA_SIZE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
      if (cfg_we) begin
        area_cfg_r <= cfg_wdata;
      end
      // Drop a taken result, raise a newly loaded one
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          start_r    <= in_data.start_sector;
          len_r      <= in_data.length_sectors;
          op_r       <= in_data.op_code;
          a_r        <= (area_cfg_r == '0) ? caws_pkg::AREA_SIZE_W'(1) : area_cfg_r;
          quo_r      <= {1'b0, in_data.start_sector};
          rem_r      <= '0;
          div_cnt_r  <= '0;
          div_pass_r <= 1'b0;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          // Hold the first quotient, start the second division
          if (!div_pass_r) begin
            first_area_r <= quo_step;
            first_rem_r  <= rem_step;
            quo_r        <= end_sector;
            rem_r        <= '0;
            div_cnt_r    <= '0;
            div_pass_r   <= 1'b1;
          end else begin
            last_area_r <= quo_step;
          end
        end else begin
          quo_r     <= quo_step;
          rem_r     <= rem_step;
          div_cnt_r <= div_cnt_r + caws_pkg::DIV_CNT_W'(1);
        end
      end
      ST_CHECK: begin
        area_r   <= first_area_r[AW-1:0];
        pos_r    <= start_r;
        remain_r <= len_r;
        room_r   <= a_r - first_rem_r;
      end
      ST_WR: begin
        // Advance to the next area, which is always a full one
        pos_r    <= pos_r + caws_pkg::SECTOR_W'(take);
        remain_r <= remain_r - take[caws_pkg::LEN_W-1:0];
        area_r   <= area_r + AW'(1);
        room_r   <= a_r;
      end
      default: ;
    endcase

    // Result register
    if (state_r == ST_WR) begin
      out_data_r.piece_sector  <= pos_r;
      out_data_r.piece_sectors <= take;
      out_data_r.sequence_id   <= seq_id;
      out_data_r.piece_op      <= op_r;
      out_data_r.range_error   <= 1'b0;
      out_data_r.last          <= piece_last;
    end else if ((state_r == ST_ERR) && slot_free) begin
      out_data_r.piece_sector  <= start_r;
      out_data_r.piece_sectors <= '0;
      out_data_r.sequence_id   <= '0;
      out_data_r.piece_op      <= op_r;
      out_data_r.range_error   <= 1'b1;
      out_data_r.last          <= 1'b1;
    end
  end

  // Sequence counter memory
  always_ff @(posedge clk) begin
    if (state_r == ST_CLEAR) begin
      mem[clr_cnt_r] <= '0;
    end else if (state_r == ST_WR) begin
      mem[area_r] <= seq_id;
    end
    rd_data_r <= mem[area_r];
  end

  // Never overwrite a result the receiver has not taken
  assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> !(out_valid_r && out_stall))
    else $error("result register overwritten while held");

  // A counter update always finds the result slot empty
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WR) |-> !out_valid_r)
    else $error("piece written with result slot occupied");

  // Rejected requests close with one final result
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.range_error) |-> out_data_r.last)
    else $error("error result without last");

  // The range check follows the second division
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK) |-> ($past(state_r) == ST_DIV) && div_pass_r)
    else $error("range check without completed divisions");

endmodule

[dv/tb_collision_area_write_splitter.sv]
`timescale 1ns / 1ps

module tb_collision_area_write_splitter;

  localparam int NUM_AREAS  = 1024;
  localparam int MAX_PIECES = 64;
  localparam int AW         = (NUM_AREAS > 1) ? $clog2(NUM_AREAS) : 1;
  localparam int IDLE_PCT   = 20;
  localparam int STALL_LIMIT = 20000;
  localparam int MAX_REPORTS = 10;

  logic                             clk;
  logic                             rst_n;
  logic                             in_valid;
  logic                             in_stall;
  caws_pkg::req_t                   in_data;
  logic                             out_valid;
  logic                             out_stall;
  caws_pkg::rsp_t                   out_data;
  logic                             cfg_we;
  logic [caws_pkg::AREA_SIZE_W-1:0] cfg_wdata;

  // Stimulus and scoreboard state
  caws_pkg::req_t                   pending_reqs[$];
  caws_pkg::rsp_t                   expected_pieces[$];
  logic [caws_pkg::SEQ_W-1:0]       area_seq[NUM_AREAS];
  logic [caws_pkg::AREA_SIZE_W-1:0] area_size;
  bit                               req_held;
  bit                               no_gaps;
  int                               mismatch_count;
  int                               quiet_cycles;

  collision_area_write_splitter #(
    .NUM_AREAS (NUM_AREAS),
    .MAX_PIECES(MAX_PIECES)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Split one request into the pieces the block should return, bumping counters
  function automatic void split_request(input caws_pkg::req_t r);
    logic [63:0] asz, first_area, last_area, n_pieces, pos, remain, room, take, k;
    caws_pkg::rsp_t p;
    asz = (area_size == '0) ? 64'd1 : 64'(area_size);
    first_area = 64'(r.start_sector) / asz;
    if (r.length_sectors == '0)
      last_area = first_area;
    else
      last_area = (64'(r.start_sector) + 64'(r.length_sectors) - 64'd1) / asz;
    n_pieces = last_area - first_area + 64'd1;
    if (n_pieces > 64'(MAX_PIECES) || last_area >= 64'(NUM_AREAS)) begin
      p = '0;
      p.piece_sector = r.start_sector;
      p.piece_op     = r.op_code;
      p.range_error  = 1'b1;
      p.last         = 1'b1;
      expected_pieces.push_back(p);
      return;
    end
    // A zero-length request falls through as a single empty piece
    pos = 64'(r.start_sector);
    remain = 64'(r.length_sectors);
    for (k = first_area; k <= last_area; k++) begin
      room = (k + 64'd1) * asz - pos;
      take = (remain < room) ? remain : room;
      area_seq[k[AW-1:0]] = area_seq[k[AW-1:0]] + caws_pkg::SEQ_W'(1);
      p = '0;
      p.piece_sector  = pos[caws_pkg::SECTOR_W-1:0];
      p.piece_sectors = take[caws_pkg::AREA_SIZE_W-1:0];
      p.sequence_id   = area_seq[k[AW-1:0]];
      p.piece_op      = r.op_code;
      p.last          = (k == last_area);
      expected_pieces.push_back(p);
      pos = pos + take;
      remain = remain - take;
    end
  endfunction

  // Input driver: present the next request, hold it until accepted
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!req_held) begin
      if (pending_reqs.size() != 0 &&
          (no_gaps || $urandom_range(0, 99) >= IDLE_PCT)) begin
        in_data  <= pending_reqs.pop_front();
        in_valid <= 1'b1;
        req_held = 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure
  always @(negedge clk) begin
    if (!rst_n)
      out_stall <= 1'b0;
    else
      out_stall <= !no_gaps && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // Predict on request acceptance, check on result acceptance, watch for hangs
  always @(posedge clk) begin
    caws_pkg::rsp_t want;
    bit             moved;
    moved = 1'b0;
    if (rst_n && in_valid && !in_stall) begin
      split_request(in_data);
      req_held = 1'b0;
      moved = 1'b1;
    end
    if (rst_n && out_valid && !out_stall) begin
      moved = 1'b1;
      if (expected_pieces.size() == 0) begin
        if (mismatch_count < MAX_REPORTS)
          $display("unexpected piece: sector=%h len=%h seq=%h op=%h err=%b last=%b",
                   out_data.piece_sector, out_data.piece_sectors, out_data.sequence_id,
                   out_data.piece_op, out_data.range_error, out_data.last);
        mismatch_count++;
      end else begin
        want = expected_pieces.pop_front();
        if (out_data.piece_sector  !== want.piece_sector  ||
            out_data.piece_sectors !== want.piece_sectors ||
            out_data.sequence_id   !== want.sequence_id   ||
            out_data.piece_op      !== want.piece_op      ||
            out_data.range_error   !== want.range_error   ||
            out_data.last          !== want.last) begin
          if (mismatch_count < MAX_REPORTS)
            $display("piece differs: expected sector=%h len=%h seq=%h op=%h err=%b last=%b,",
                     want.piece_sector, want.piece_sectors, want.sequence_id,
                     want.piece_op, want.range_error, want.last,
                     " got sector=%h len=%h seq=%h op=%h err=%b last=%b",
                     out_data.piece_sector, out_data.piece_sectors, out_data.sequence_id,
                     out_data.piece_op, out_data.range_error, out_data.last);
          mismatch_count++;
        end
      end
    end
    if (!rst_n || moved)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("collision_area_write_splitter: mismatch");
      $finish;
    end
  end

  task automatic add_req(input logic [caws_pkg::SECTOR_W-1:0] start,
                         input logic [caws_pkg::LEN_W-1:0] len,
                         input logic [caws_pkg::OP_W-1:0] op);
    caws_pkg::req_t r;
    r.start_sector   = start;
    r.length_sectors = len;
    r.op_code        = op;
    pending_reqs.push_back(r);
  endtask

  // Mostly well-formed requests inside the table, some zero-length, the rest possibly out of bounds or oversized
  task automatic add_random_reqs(input int n);
    logic [63:0] asz, first_area, last_area, s, e, len;
    int kind;
    repeat (n) begin
      asz = (area_size == '0) ? 64'd1 : 64'(area_size);
      kind = int'($urandom_range(0, 99));
      first_area = 64'($urandom_range(0, NUM_AREAS - 1));
      s = first_area * asz + 64'($urandom_range(0, 32'(asz - 1)));
      if (kind < 70) begin
        if ($urandom_range(0, 9) == 0)
          last_area = first_area + 64'($urandom_range(0, MAX_PIECES - 1));
        else
          last_area = first_area + 64'($urandom_range(0, 3));
        if (last_area >= 64'(NUM_AREAS))
          last_area = 64'(NUM_AREAS - 1);
        e = last_area * asz + 64'($urandom_range(0, 32'(asz - 1)));
        if (e < s)
          e = s;
        len = e - s + 64'd1;
        if (len > 64'd65535)
          len = 64'd65535 - 64'($urandom_range(0, 15));
      end else if (kind < 80) begin
        len = 64'd0;
      end else if (kind < 90) begin
        len = 64'($urandom_range(0, 65535));
      end else begin
        s = 64'($urandom());
        len = 64'($urandom_range(0, 65535));
      end
      add_req(s[caws_pkg::SECTOR_W-1:0], len[caws_pkg::LEN_W-1:0],
              caws_pkg::OP_W'($urandom_range(0, 255)));
    end
  endtask

  // Let everything queued drain out before touching the register or ending
  task automatic drain();
    while (pending_reqs.size() != 0 || req_held || expected_pieces.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_area_size(input logic [caws_pkg::AREA_SIZE_W-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    area_size = v;
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    req_held  = 1'b0;
    no_gaps   = 1'b0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    area_size = caws_pkg::AREA_SIZE_RESET;
    foreach (area_seq[i])
      area_seq[i] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset area size: corner requests
    add_req(32'd0, 16'd0, 8'h00);
    add_req(32'd0, 16'd1, 8'hff);
    add_req(32'd0, 16'd1, 8'h5a);
    add_req(32'd7, 16'd2, 8'h01);
    add_req(32'd5, 16'd3, 8'h80);
    add_req(32'd0, 16'd512, 8'h11);
    add_req(32'd0, 16'd513, 8'h22);
    add_req(32'd1, 16'd512, 8'h33);
    add_req(32'd8184, 16'd8, 8'h44);
    add_req(32'd8184, 16'd9, 8'h55);
    add_req(32'd8191, 16'd0, 8'h66);
    add_req(32'd8192, 16'd0, 8'h77);
    add_req(32'hffff_ffff, 16'hffff, 8'ha5);
    add_req(32'hffff_ffff, 16'd0, 8'h3c);
    add_req(32'd100, 16'hffff, 8'hc3);
    add_random_reqs(40);

    // Unit areas, run back to back with no gaps on either side
    set_area_size(caws_pkg::AREA_SIZE_W'(1));
    no_gaps = 1'b1;
    add_req(32'd0, 16'd64, 8'h01);
    add_req(32'd0, 16'd65, 8'h02);
    add_req(32'd1023, 16'd1, 8'h03);
    add_req(32'd1024, 16'd1, 8'h04);
    add_random_reqs(35);
    drain();
    no_gaps = 1'b0;

    // Zero acts as one
    set_area_size(caws_pkg::AREA_SIZE_W'(0));
    add_random_reqs(30);

    set_area_size(caws_pkg::AREA_SIZE_W'(65536));
    add_random_reqs(35);

    // Largest register value
    set_area_size(caws_pkg::AREA_SIZE_W'(131071));
    add_req(32'd0, 16'hffff, 8'h10);
    add_req(32'd131070, 16'd2, 8'h20);
    add_req(32'd134086632, 16'd0, 8'h30);
    add_random_reqs(35);

    set_area_size(caws_pkg::AREA_SIZE_W'(3));
    add_random_reqs(40);

    set_area_size(caws_pkg::AREA_SIZE_W'($urandom_range(2, 200)));
    add_random_reqs(45);

    drain();
    repeat (80) @(negedge clk);
    if (mismatch_count == 0)
      $display("collision_area_write_splitter: match");
    else
      $display("collision_area_write_splitter: mismatch");
    $finish;
  end

endmodule

[files.f]
hdl/caws_pkg.sv
hdl/collision_area_write_splitter.sv
dv/tb_collision_area_write_splitter.sv
